FILE: sv/owsp_pkg.sv
// owsp_pkg: shared types and constants of the 1-Wire scratchpad command layer.
// Item structs, configuration struct, operation and command codes, phase enum.
// No dependencies.
`default_nettype none

package owsp_pkg;

  // bus event codes carried in the operation field
  localparam logic [2:0] OP_BUS_RESET   = 3'd0;
  localparam logic [2:0] OP_HOST_WRITE  = 3'd1;
  localparam logic [2:0] OP_HOST_RD_BYTE = 3'd2;
  localparam logic [2:0] OP_HOST_RD_BIT = 3'd3;
  localparam logic [2:0] OP_LOCAL_WRITE = 3'd4;

  // function commands
  localparam logic [7:0] CMD_CONVERT    = 8'h44;
  localparam logic [7:0] CMD_READ_PAD   = 8'hBE;
  localparam logic [7:0] CMD_WRITE_PAD  = 8'h4E;
  localparam logic [7:0] CMD_READ_POWER = 8'hB4;

  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  // configuration register indexes
  localparam logic REG_SLEEP_HINT = 1'b0;
  localparam logic REG_EXT_POWER  = 1'b1;

  localparam logic [7:0] SLEEP_HINT_RESET = 8'd8;
  localparam logic       EXT_POWER_RESET  = 1'b1;

  typedef enum logic [2:0] {
    PH_COMMAND,
    PH_SEND,
    PH_RECV,
    PH_POWER,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] host_data;
    logic [3:0] scratch_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       measure_request;
    logic       settings_written;
    logic [7:0] sleep_hint;
  } out_item_t;

  typedef struct packed {
    logic [7:0] sleep_hint_value;
    logic       external_power;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/owsp_apb_regs.sv
// owsp_apb_regs: APB-style configuration registers (sleep hint, power bit).
// Depends on owsp_pkg.
`default_nettype none

module owsp_apb_regs
  import owsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_SLEEP_HINT: cfg_d.sleep_hint_value = pwdata[7:0];
        REG_EXT_POWER:  cfg_d.external_power   = pwdata[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sleep_hint_value <= SLEEP_HINT_RESET;
      cfg_q.external_power   <= EXT_POWER_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SLEEP_HINT: prdata = {24'd0, cfg_q.sleep_hint_value};
      REG_EXT_POWER:  prdata = {31'd0, cfg_q.external_power};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: sv/owsp_cmd_engine.sv
// owsp_cmd_engine: command phase, byte counter and scratchpad; works out the
// result of the registered item and updates state when that item moves on.
// Depends on owsp_pkg.
`default_nettype none

module owsp_cmd_engine
  import owsp_pkg::*;
#(
  parameter int SCRATCH_BYTES = 9
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     advance_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output out_item_t     result_o
);

  localparam int IdxW = (SCRATCH_BYTES > 1) ? $clog2(SCRATCH_BYTES) : 1;
  localparam logic [4:0] NumBytes = 5'(SCRATCH_BYTES);

  phase_e     phase_q, phase_d;
  logic [3:0] cnt_q, cnt_d;
  logic [4:0] cnt_inc;
  logic       cnt_in_range;
  logic       idx_in_range;

  logic [7:0] pad_q [SCRATCH_BYTES];
  logic            pad_we;
  logic [IdxW-1:0] pad_waddr;
  logic [7:0]      pad_wdata;
  logic [7:0]      pad_rdata;

  assign cnt_inc      = {1'b0, cnt_q} + 5'd1;
  assign cnt_in_range = {1'b0, cnt_q} < NumBytes;
  assign idx_in_range = {1'b0, item_i.scratch_index} < NumBytes;
  assign pad_rdata    = pad_q[cnt_q[IdxW-1:0]];

  // next phase and byte count
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    case (item_i.operation)
      OP_BUS_RESET: begin
        phase_d = PH_COMMAND;
        cnt_d   = 4'd0;
      end
      OP_HOST_WRITE: begin
        if (phase_q == PH_COMMAND) begin
          cnt_d = 4'd0;
          case (item_i.host_data)
            CMD_READ_PAD:   phase_d = PH_SEND;
            CMD_WRITE_PAD:  phase_d = PH_RECV;
            CMD_READ_POWER: phase_d = PH_POWER;
            default:        phase_d = PH_DONE;
          endcase
        end else if (phase_q == PH_RECV) begin
          if (cnt_inc >= NumBytes) begin
            cnt_d   = 4'd0;
            phase_d = PH_DONE;
          end else begin
            cnt_d = cnt_inc[3:0];
          end
        end
      end
      OP_HOST_RD_BYTE: begin
        if (phase_q == PH_SEND) begin
          if (cnt_inc >= NumBytes) begin
            cnt_d   = 4'd0;
            phase_d = PH_DONE;
          end else begin
            cnt_d = cnt_inc[3:0];
          end
        end
      end
      OP_HOST_RD_BIT: begin
        if (phase_q == PH_POWER) phase_d = PH_DONE;
      end
      default: ;
    endcase
  end

  // result item and scratchpad write port
  always_comb begin
    result_o.read_data        = IDLE_BYTE;
    result_o.read_valid       = 1'b0;
    result_o.measure_request  = 1'b0;
    result_o.settings_written = 1'b0;
    result_o.sleep_hint       = 8'd0;
    pad_we    = 1'b0;
    pad_waddr = cnt_q[IdxW-1:0];
    pad_wdata = item_i.host_data;
    case (item_i.operation)
      OP_HOST_WRITE: begin
        if (phase_q == PH_COMMAND) begin
          if (item_i.host_data == CMD_CONVERT) begin
            result_o.measure_request = 1'b1;
            result_o.sleep_hint      = cfg_i.sleep_hint_value;
          end
        end else if (phase_q == PH_RECV) begin
          pad_we = cnt_in_range;
          if (cnt_inc >= NumBytes) begin
            result_o.measure_request  = 1'b1;
            result_o.settings_written = 1'b1;
          end
        end
      end
      OP_HOST_RD_BYTE: begin
        if (phase_q == PH_SEND) begin
          if (cnt_in_range) result_o.read_data = pad_rdata;
          result_o.read_valid = 1'b1;
        end
      end
      OP_HOST_RD_BIT: begin
        if (phase_q == PH_POWER) begin
          result_o.read_data  = {7'd0, cfg_i.external_power};
          result_o.read_valid = 1'b1;
        end
      end
      OP_LOCAL_WRITE: begin
        pad_we    = idx_in_range;
        pad_waddr = item_i.scratch_index[IdxW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COMMAND;
      cnt_q   <= 4'd0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SCRATCH_BYTES; i++) pad_q[i] <= 8'd0;
    end else if (advance_i && pad_we) begin
      pad_q[pad_waddr] <= pad_wdata;
    end
  end

endmodule

`default_nettype wire

FILE: sv/onewire_scratchpad_command_layer_core.sv
// Function-command layer of a 1-Wire slave with a scratchpad, driven by
// byte-level bus events (bus reset, host byte write, host byte/bit read,
// local scratchpad write).
//
// Input channel in_valid_i / in_stall_o carries one event item; the output
// channel out_valid_o / out_stall_i returns exactly one result item per event.
// An item is taken into an input register, its result is worked out
// combinationally and held in an output register, from which it can be
// taken; throughput is one item per cycle while the output is not stalled.
// While the output is stalled the held result stays put and one more item is
// taken into the input register; in_stall_o rises only when both are full.
//
// Reset (rst_ni low, asynchronous) empties both registers, returns the layer
// to awaiting a command, clears the scratchpad and loads the configuration
// reset values (sleep hint 8, external power 1). The APB-style port holds
// the sleep hint at 0x0 and the power bit at 0x4; write it only while idle.
// Depends on owsp_pkg, owsp_apb_regs, owsp_cmd_engine.
`default_nettype none

module onewire_scratchpad_command_layer_core
  import owsp_pkg::*;
#(
  parameter int SCRATCH_BYTES = 9
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_item_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t result;
  logic      advance;
  logic      in_take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  owsp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  owsp_cmd_engine #(
    .SCRATCH_BYTES (SCRATCH_BYTES)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/owsp_checker.sv
// owsp_checker: port-level checks on the command layer's result items,
// bound to onewire_scratchpad_command_layer_core. Depends on owsp_pkg.
`default_nettype none

module owsp_checker
  import owsp_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  // a held result item must not move
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  a_idle_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.read_valid |-> out_item_o.read_data == IDLE_BYTE)
    else $error("idle answer not all ones");

  a_settings_measure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.settings_written |->
      out_item_o.measure_request && !out_item_o.read_valid)
    else $error("settings pulse without measure request");

  // sleep hint only comes with a convert command
  a_sleep_convert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.sleep_hint != 8'd0 |->
      out_item_o.measure_request && !out_item_o.settings_written &&
      !out_item_o.read_valid)
    else $error("sleep hint outside convert");

endmodule

bind onewire_scratchpad_command_layer_core owsp_checker u_owsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
